// ===== src/static_linked_list_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// static_linked_list_engine_unit_macros
// assertion macros used by the linked list engine unit
// ----------------------------------------------------------------------------
`ifndef STATIC_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define STATIC_LINKED_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication under reset
`define SLL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sll: same-cycle check failed");

// next-cycle implication under reset
`define SLL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sll: next-cycle check failed");

`endif

// ===== src/sll_pkg.sv =====
// ----------------------------------------------------------------------------
// sll_pkg
// widths, codes and the link store request type of the linked list engine
// ----------------------------------------------------------------------------
package sll_pkg;

	localparam int REQ_W  = 2;
	localparam int POS_W  = 6;
	localparam int VAL_W  = 8;
	localparam int ST_W   = 2;
	localparam int CNT_W  = 6;
	localparam int LINK_W = 6;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT   = 2'd0,
		REQ_DELETE   = 2'd1,
		REQ_TRAVERSE = 2'd2,
		REQ_NONE     = 2'd3
	} req_code_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_code_t;

	// one read and one write on the link store per cycle
	typedef struct packed {
		logic              rd_en;
		logic [LINK_W-1:0] rd_addr;
		logic              wr_en;
		logic [LINK_W-1:0] wr_addr;
		logic [LINK_W-1:0] wr_data;
	} link_req_t;

endpackage

// ===== src/sll_if.sv =====
// ----------------------------------------------------------------------------
// sll_if
// request and response channels of the linked list engine
// ----------------------------------------------------------------------------
interface sll_in_if;
	import sll_pkg::*;

	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] value;

	modport source (output valid, output req_type, output position, output value,
		input ready);
	modport sink (input valid, input req_type, input position, input value,
		output ready);
endinterface

interface sll_out_if;
	import sll_pkg::*;

	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic [CNT_W-1:0] count;
	logic [VAL_W-1:0] item;
	logic             last;

	modport source (output valid, output status, output count, output item,
		output last, input ready);
	modport sink (input valid, input status, input count, input item,
		input last, output ready);
endinterface

// ===== src/sll_ram.sv =====
// ----------------------------------------------------------------------------
// sll_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/sll_link_store.sv =====
// ----------------------------------------------------------------------------
// sll_link_store
// next-link store: ram plus per-entry valid bits that stand in for the
// reset chain (entry i links to i+1, the list head links to 0)
// ----------------------------------------------------------------------------
module sll_link_store #(
	parameter int NODES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sll_pkg::link_req_t        lreq,
	output logic [$clog2(NODES)-1:0]  rdata
);
	import sll_pkg::*;

	localparam int IW = $clog2(NODES);
	localparam logic [IW-1:0] HEAD = IW'(NODES - 1);

	logic [NODES-1:0] valid_q;
	logic             rd_valid_q;
	logic [IW-1:0]    rd_addr_q;
	logic [IW-1:0]    ram_rdata;

	sll_ram #(
		.WIDTH(IW),
		.DEPTH(NODES)
	) u_ram (
		.clk   (clk),
		.we    (lreq.wr_en),
		.waddr (lreq.wr_addr[IW-1:0]),
		.wdata (lreq.wr_data[IW-1:0]),
		.re    (lreq.rd_en),
		.raddr (lreq.rd_addr[IW-1:0]),
		.rdata (ram_rdata)
	);

	// valid bits and the read-side tag that picks ram or reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			rd_addr_q  <= '0;
		end else begin
			if (lreq.wr_en) begin
				valid_q[lreq.wr_addr[IW-1:0]] <= 1'b1;
			end
			if (lreq.rd_en) begin
				rd_valid_q <= valid_q[lreq.rd_addr[IW-1:0]];
				rd_addr_q  <= lreq.rd_addr[IW-1:0];
			end
		end
	end

	// never-written entry reads as its reset link
	always_comb begin
		if (rd_valid_q) begin
			rdata = ram_rdata;
		end else if (rd_addr_q == HEAD) begin
			rdata = '0;
		end else begin
			rdata = IW'(rd_addr_q + 1'b1);
		end
	end

endmodule

// ===== src/static_linked_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine_unit
// cursor-linked byte list with a free chain, run by a small sequencer over
// one link store port and one data store port
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, position, value
//  rsp      out  valid/ready    status, count, item, last
//
//  insert and delete walk the list link by link up to the position; the walk
//  is one link store read per cycle, and that single read port sets the pace.
//  traverse gives one item per cycle while rsp is taken.
//  a rejected or unused request gets a single status response.
//  reset is immediate: link store valid bits clear at once, no clearing pass.
//  req is ready only while idle; a stalled rsp holds the sequencer in place.
// ----------------------------------------------------------------------------
`include "static_linked_list_engine_unit_macros.svh"

module static_linked_list_engine_unit #(
	parameter int NODES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	sll_in_if.sink    req,
	sll_out_if.source rsp
);
	import sll_pkg::*;

	localparam int IW = $clog2(NODES);
	localparam logic [IW-1:0]    HEAD    = IW'(NODES - 1);
	localparam logic [IW-1:0]    FREE_HD = '0;
	localparam logic [CNT_W-1:0] CAP     = CNT_W'(NODES - 2);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_INS_FREE,
		S_INS_POP,
		S_WALK_RD,
		S_INS_LINK,
		S_DEL_V,
		S_DEL_F,
		S_DEL_PUSH,
		S_TRV_ADDR,
		S_TRV_OUT,
		S_RESP
	} state_t;

	state_t           state_q;
	req_code_t        req_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] steps_q;
	logic [IW-1:0]    cur_q;
	logic [IW-1:0]    aux_q;
	status_code_t     status_q;

	logic             out_valid_q;
	status_code_t     out_status_q;
	logic [CNT_W-1:0] out_count_q;
	logic [VAL_W-1:0] out_item_q;
	logic             out_last_q;

	link_req_t        lreq;
	logic [IW-1:0]    link_rdata;
	logic             d_we;
	logic             d_re;
	logic [IW-1:0]    d_waddr;
	logic [IW-1:0]    d_raddr;
	logic [VAL_W-1:0] d_rdata;

	logic             out_free;
	logic             out_load;
	logic             ins_range_bad;
	logic             del_range_bad;
	logic             store_full;
	logic             free_bad;

	// stores
	sll_link_store #(
		.NODES(NODES)
	) u_links (
		.clk    (clk),
		.arst_n (arst_n),
		.lreq   (lreq),
		.rdata  (link_rdata)
	);

	sll_ram #(
		.WIDTH(VAL_W),
		.DEPTH(NODES)
	) u_data (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (val_q),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	// request checks
	assign out_free      = !out_valid_q || rsp.ready;
	assign out_load      = out_free && (state_q == S_TRV_OUT || state_q == S_RESP);
	assign ins_range_bad = (pos_q == '0) ||
		({1'b0, pos_q} > ({1'b0, cnt_q} + (CNT_W + 1)'(1)));
	assign del_range_bad = (pos_q == '0) || ({1'b0, pos_q} > {1'b0, cnt_q});
	assign store_full    = (cnt_q >= CAP);
	assign free_bad      = (link_rdata == FREE_HD) || (link_rdata == HEAD);

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.count  = out_count_q;
	assign rsp.item   = out_item_q;
	assign rsp.last   = out_last_q;

	// store port requests for each sequencer step
	always_comb begin
		lreq    = '0;
		d_we    = 1'b0;
		d_re    = 1'b0;
		d_waddr = link_rdata;
		d_raddr = link_rdata;
		case (state_q)
			S_CHECK: begin
				case (req_q)
					REQ_INSERT: begin
						if (!ins_range_bad && !store_full) begin
							lreq.rd_en   = 1'b1;
							lreq.rd_addr = LINK_W'(FREE_HD);
						end
					end
					REQ_DELETE: begin
						if (!del_range_bad) begin
							lreq.rd_en   = 1'b1;
							lreq.rd_addr = LINK_W'(HEAD);
						end
					end
					REQ_TRAVERSE: begin
						if (cnt_q != '0) begin
							lreq.rd_en   = 1'b1;
							lreq.rd_addr = LINK_W'(HEAD);
						end
					end
					default: begin
					end
				endcase
			end
			S_INS_FREE: begin
				if (!free_bad) begin
					lreq.rd_en   = 1'b1;
					lreq.rd_addr = LINK_W'(link_rdata);
					d_we         = 1'b1;
				end
			end
			S_INS_POP: begin
				lreq.wr_en   = 1'b1;
				lreq.wr_addr = LINK_W'(FREE_HD);
				lreq.wr_data = LINK_W'(link_rdata);
				lreq.rd_en   = 1'b1;
				lreq.rd_addr = LINK_W'(HEAD);
			end
			S_WALK_RD: begin
				if (steps_q == '0 && req_q == REQ_INSERT) begin
					lreq.wr_en   = 1'b1;
					lreq.wr_addr = LINK_W'(aux_q);
					lreq.wr_data = LINK_W'(link_rdata);
				end else begin
					lreq.rd_en   = 1'b1;
					lreq.rd_addr = LINK_W'(link_rdata);
				end
			end
			S_INS_LINK: begin
				lreq.wr_en   = 1'b1;
				lreq.wr_addr = LINK_W'(cur_q);
				lreq.wr_data = LINK_W'(aux_q);
			end
			S_DEL_V: begin
				lreq.wr_en   = 1'b1;
				lreq.wr_addr = LINK_W'(cur_q);
				lreq.wr_data = LINK_W'(link_rdata);
				lreq.rd_en   = 1'b1;
				lreq.rd_addr = LINK_W'(FREE_HD);
			end
			S_DEL_F: begin
				lreq.wr_en   = 1'b1;
				lreq.wr_addr = LINK_W'(aux_q);
				lreq.wr_data = LINK_W'(link_rdata);
			end
			S_DEL_PUSH: begin
				lreq.wr_en   = 1'b1;
				lreq.wr_addr = LINK_W'(FREE_HD);
				lreq.wr_data = LINK_W'(aux_q);
			end
			S_TRV_ADDR: begin
				lreq.rd_en   = 1'b1;
				lreq.rd_addr = LINK_W'(link_rdata);
				d_re         = 1'b1;
			end
			S_TRV_OUT: begin
				if (out_free && steps_q != CNT_W'(1)) begin
					lreq.rd_en   = 1'b1;
					lreq.rd_addr = LINK_W'(link_rdata);
					d_re         = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= REQ_NONE;
			pos_q        <= '0;
			val_q        <= '0;
			cnt_q        <= '0;
			steps_q      <= '0;
			cur_q        <= '0;
			aux_q        <= '0;
			status_q     <= ST_OK;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_count_q  <= '0;
			out_item_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q   <= req_code_t'(req.req_type);
						pos_q   <= req.position;
						val_q   <= req.value;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					status_q <= ST_OK;
					state_q  <= S_RESP;
					case (req_q)
						REQ_INSERT: begin
							if (ins_range_bad) begin
								status_q <= ST_RANGE;
							end else if (store_full) begin
								status_q <= ST_FULL;
							end else begin
								state_q <= S_INS_FREE;
							end
						end
						REQ_DELETE: begin
							if (del_range_bad) begin
								status_q <= ST_RANGE;
							end else begin
								cur_q   <= HEAD;
								steps_q <= CNT_W'(pos_q - 1'b1);
								state_q <= S_WALK_RD;
							end
						end
						REQ_TRAVERSE: begin
							if (cnt_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								steps_q <= cnt_q;
								state_q <= S_TRV_ADDR;
							end
						end
						default: begin
						end
					endcase
				end
				S_INS_FREE: begin
					if (free_bad) begin
						status_q <= ST_FULL;
						state_q  <= S_RESP;
					end else begin
						aux_q   <= link_rdata;
						state_q <= S_INS_POP;
					end
				end
				S_INS_POP: begin
					cur_q   <= HEAD;
					steps_q <= CNT_W'(pos_q - 1'b1);
					state_q <= S_WALK_RD;
				end
				S_WALK_RD: begin
					// link_rdata is the successor of cur_q
					if (steps_q != '0) begin
						cur_q   <= link_rdata;
						steps_q <= steps_q - 1'b1;
					end else if (req_q == REQ_INSERT) begin
						state_q <= S_INS_LINK;
					end else begin
						aux_q   <= link_rdata;
						state_q <= S_DEL_V;
					end
				end
				S_INS_LINK: begin
					cnt_q    <= cnt_q + 1'b1;
					status_q <= ST_OK;
					state_q  <= S_RESP;
				end
				S_DEL_V: begin
					state_q <= S_DEL_F;
				end
				S_DEL_F: begin
					state_q <= S_DEL_PUSH;
				end
				S_DEL_PUSH: begin
					cnt_q    <= cnt_q - 1'b1;
					status_q <= ST_OK;
					state_q  <= S_RESP;
				end
				S_TRV_ADDR: begin
					cur_q   <= link_rdata;
					state_q <= S_TRV_OUT;
				end
				S_TRV_OUT: begin
					if (out_free) begin
						out_status_q <= ST_OK;
						out_count_q  <= cnt_q;
						out_item_q   <= d_rdata;
						out_last_q   <= (steps_q == CNT_W'(1));
						if (steps_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							cur_q   <= link_rdata;
							steps_q <= steps_q - 1'b1;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_status_q <= status_q;
						out_count_q  <= cnt_q;
						out_item_q   <= '0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`SLL_ASSERT_IMP(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CAP)
	`SLL_ASSERT_IMP(a_walk_in_list, clk, arst_n, state_q == S_WALK_RD && steps_q != '0, link_rdata != FREE_HD && link_rdata != HEAD)
	`SLL_ASSERT_IMP(a_trv_node, clk, arst_n, state_q == S_TRV_OUT, cur_q != FREE_HD && cur_q != HEAD)
	`SLL_ASSERT_NXT(a_accept_busy, clk, arst_n, req.valid && req.ready, state_q == S_CHECK && !req.ready)

endmodule
